/* src/csvt_pkg.sv */
package csvt_pkg;

   localparam logic [7:0] QuoteByte = 8'h22;
   localparam logic [7:0] CrByte    = 8'h0d;
   localparam logic [7:0] LfByte    = 8'h0a;
   localparam logic [7:0] CommaByte = 8'h2c;

   localparam int MaxTokens = 3;

   localparam logic CsrDelimiter = 1'b0;

   typedef enum logic [2:0] {
      ST_FIELD_START = 3'd0,
      ST_UNQUOTED    = 3'd1,
      ST_QUOTED      = 3'd2,
      ST_QUOTE_SEEN  = 3'd3,
      ST_AFTER_CR    = 3'd4
   } scan_state_type;

   typedef enum logic [1:0] {
      TOK_CONTENT = 2'd0,
      TOK_FIELD   = 2'd1,
      TOK_RECORD  = 2'd2
   } token_kind_type;

   typedef struct packed {
      token_kind_type kind;
      logic [7:0]     value;
   } token_type;

   typedef struct packed {
      logic                          load;
      logic [1:0]                    count;
      token_type [MaxTokens-1:0]     tok;
   } scan_out_type;

endpackage

/* src/csvt_scan.sv */
module csvt_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  commit,
   input  logic [7:0]            text_byte,
   input  logic                  end_of_text,
   input  logic [7:0]            delimiter,
   output csvt_pkg::scan_out_type scan_out
);
   import csvt_pkg::*;

   scan_state_type scan_ff, scan_in, eff_state;
   logic           open_ff, open_in, open_pre;
   logic           swallow, is_quote, is_delim, is_cr, is_lf, is_sep;
   logic [1:0]     out_cnt;
   token_type [MaxTokens-1:0] out_tok;

   always_comb begin
      is_quote = (text_byte == QuoteByte);
      is_delim = (text_byte == delimiter);
      is_cr    = (text_byte == CrByte);
      is_lf    = (text_byte == LfByte);
      is_sep   = is_delim || is_cr || is_lf;
      swallow  = 1'b0;
      eff_state = scan_ff;
      if (scan_ff == ST_AFTER_CR) begin
         eff_state = ST_FIELD_START;
         swallow   = is_lf;
      end
   end

   always_comb begin
      scan_in = eff_state;
      open_in = open_ff;
      if (!swallow) begin
         case (eff_state)
            ST_UNQUOTED: begin
               if (is_delim) begin
                  scan_in = ST_FIELD_START;
                  open_in = 1'b1;
               end else if (is_cr) begin
                  scan_in = ST_AFTER_CR;
                  open_in = 1'b0;
               end else if (is_lf) begin
                  scan_in = ST_FIELD_START;
                  open_in = 1'b0;
               end
            end
            ST_QUOTED: begin
               if (is_quote) scan_in = ST_QUOTE_SEEN;
            end
            ST_QUOTE_SEEN: begin
               if (is_quote) begin
                  scan_in = ST_QUOTED;
               end else if (is_delim) begin
                  scan_in = ST_FIELD_START;
                  open_in = 1'b1;
               end else if (is_cr) begin
                  scan_in = ST_AFTER_CR;
                  open_in = 1'b0;
               end else if (is_lf) begin
                  scan_in = ST_FIELD_START;
                  open_in = 1'b0;
               end else begin
                  scan_in = ST_UNQUOTED;
               end
            end
            default: begin
               if (is_quote) begin
                  scan_in = ST_QUOTED;
                  open_in = 1'b1;
               end else if (is_delim) begin
                  scan_in = ST_FIELD_START;
                  open_in = 1'b1;
               end else if (is_cr) begin
                  scan_in = ST_AFTER_CR;
                  open_in = 1'b0;
               end else if (is_lf) begin
                  scan_in = ST_FIELD_START;
                  open_in = 1'b0;
               end else begin
                  scan_in = ST_UNQUOTED;
                  open_in = 1'b1;
               end
            end
         endcase
      end
      open_pre = open_in;
      if (end_of_text) begin
         scan_in = ST_FIELD_START;
         open_in = 1'b0;
      end
   end

   always_comb begin
      out_cnt = 2'd0;
      out_tok = '0;
      if (!swallow) begin
         case (eff_state)
            ST_QUOTED: begin
               if (!is_quote) begin
                  out_tok[out_cnt] = '{kind: TOK_CONTENT, value: text_byte};
                  out_cnt = out_cnt + 2'd1;
               end
            end
            ST_QUOTE_SEEN: begin
               if (is_quote) begin
                  out_tok[out_cnt] = '{kind: TOK_CONTENT, value: QuoteByte};
                  out_cnt = out_cnt + 2'd1;
               end else if (is_delim) begin
                  out_tok[out_cnt] = '{kind: TOK_FIELD, value: 8'h00};
                  out_cnt = out_cnt + 2'd1;
               end else if (is_sep) begin
                  out_tok[out_cnt] = '{kind: TOK_RECORD, value: 8'h00};
                  out_cnt = out_cnt + 2'd1;
               end else begin
                  out_tok[0] = '{kind: TOK_FIELD, value: 8'h00};
                  out_tok[1] = '{kind: TOK_CONTENT, value: text_byte};
                  out_cnt = 2'd2;
               end
            end
            default: begin
               if (is_quote && eff_state != ST_UNQUOTED) begin
                  out_cnt = 2'd0;
               end else if (is_delim) begin
                  out_tok[out_cnt] = '{kind: TOK_FIELD, value: 8'h00};
                  out_cnt = out_cnt + 2'd1;
               end else if (is_sep) begin
                  out_tok[out_cnt] = '{kind: TOK_RECORD, value: 8'h00};
                  out_cnt = out_cnt + 2'd1;
               end else begin
                  out_tok[out_cnt] = '{kind: TOK_CONTENT, value: text_byte};
                  out_cnt = out_cnt + 2'd1;
               end
            end
         endcase
      end
      if (end_of_text && open_pre) begin
         out_tok[out_cnt] = '{kind: TOK_RECORD, value: 8'h00};
         out_cnt = out_cnt + 2'd1;
      end
   end

   assign scan_out.load  = commit;
   assign scan_out.count = out_cnt;
   assign scan_out.tok   = out_tok;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= ST_FIELD_START;
         open_ff <= 1'b0;
      end else if (commit) begin
         scan_ff <= scan_in;
         open_ff <= open_in;
      end
   end

endmodule

/* src/csvt_obuf.sv */
module csvt_obuf (
   input  logic                   clock,
   input  logic                   reset,
   input  csvt_pkg::scan_out_type scan_out,
   output logic                   free,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_token_kind,
   output logic [7:0]             rsp_content_byte,
   output logic                   rsp_run_last
);
   import csvt_pkg::*;

   token_type [MaxTokens-1:0] tok_ff;
   logic [1:0] rem_ff, rem_in;
   logic [1:0] pos_ff, pos_in;
   logic       xfer;
   token_type  head;

   assign rsp_valid = (rem_ff != 2'd0);
   assign xfer      = rsp_valid && !rsp_stall;
   assign free      = (rem_ff == 2'd0) || (rem_ff == 2'd1 && xfer);
   assign head      = tok_ff[pos_ff];

   assign rsp_token_kind   = head.kind;
   assign rsp_content_byte = head.value;
   assign rsp_run_last     = (rem_ff == 2'd1);

   always_comb begin
      rem_in = rem_ff;
      pos_in = pos_ff;
      if (scan_out.load) begin
         rem_in = scan_out.count;
         pos_in = 2'd0;
      end else if (xfer) begin
         rem_in = rem_ff - 2'd1;
         pos_in = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
         pos_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_out.load) tok_ff <= scan_out.tok;
   end

endmodule

/* src/csv_record_tokenizer.sv */
// A byte transfer on req_ is registered in the input stage; once the result buffer is
// free, its results are loaded into that buffer and presented on rsp_ from there.
// Throughput: one byte per cycle while each byte gives at most one result and rsp_stall
// is low; a byte that gives more results holds the input as the result buffer drains.
// Reset: synchronous, active high; clears scanner state, record flag and result
// buffer, and sets the delimiter to comma.
module csv_record_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_token_kind,
   output logic [7:0]  rsp_content_byte,
   output logic        rsp_run_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import csvt_pkg::*;

   logic       in_vld_ff, in_vld_in;
   logic [7:0] byte_ff;
   logic       eot_ff;
   logic [7:0] delim_ff;
   logic       free, commit, take;
   scan_out_type scan_out;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CsrDelimiter) ? {24'h0, delim_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= CommaByte;
      end else if (psel && penable && pwrite && pready && paddr[2] == CsrDelimiter) begin
         delim_ff <= pwdata[7:0];
      end
   end

   assign commit    = in_vld_ff && free;
   assign req_stall = in_vld_ff && !free;
   assign take      = req_valid && !req_stall;
   assign in_vld_in = take || (in_vld_ff && !commit);

   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else       in_vld_ff <= in_vld_in;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_text_byte;
         eot_ff  <= req_end_of_text;
      end
   end

   csvt_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .commit      (commit),
      .text_byte   (byte_ff),
      .end_of_text (eot_ff),
      .delimiter   (delim_ff),
      .scan_out    (scan_out)
   );

   csvt_obuf u_obuf (
      .clock            (clock),
      .reset            (reset),
      .scan_out         (scan_out),
      .free             (free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_content_byte (rsp_content_byte),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

/* src/csvt_checker.sv */
module csvt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_token_kind,
   input logic [7:0]  rsp_content_byte,
   input logic        rsp_run_last
);
   import csvt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind)
         && $stable(rsp_content_byte) && $stable(rsp_run_last))
      else $error("stalled result transfer changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result pending after reset");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_kind <= TOK_RECORD)
      else $error("illegal token kind");

   a_mark_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind != TOK_CONTENT |-> rsp_content_byte == 8'h00)
      else $error("mark token carries a byte");

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

endmodule

bind csv_record_tokenizer csvt_checker u_csvt_checker (.*);

/* verif/csv_record_tokenizer_tb.sv */
module csv_record_tokenizer_tb;
   import csvt_pkg::*;

   localparam int QuietLimit = 1000;
   localparam logic [2:0] DelimiterAddr = {CsrDelimiter, 2'b00};

   typedef struct packed {
      token_kind_type kind;
      logic [7:0]     content;
      logic           last;
   } token_expect_type;

   typedef token_expect_type [0:2] token_triple_type;

   typedef struct packed {
      logic [7:0]       text;
      logic             eot;
      logic             typed;
      logic [1:0]       count;
      token_triple_type toks;
   } directed_row_type;

   typedef struct packed {
      logic [7:0] text;
      logic       eot;
   } text_item_type;

   localparam token_expect_type NoTok     = '0;
   localparam token_expect_type FieldMid  = '{TOK_FIELD, 8'h00, 1'b0};
   localparam token_expect_type FieldLast = '{TOK_FIELD, 8'h00, 1'b1};
   localparam token_expect_type RecLast   = '{TOK_RECORD, 8'h00, 1'b1};

   localparam directed_row_type DirectedRows [25] = '{
      '{8'h61,     1'b0, 1'b1, 2'd1, '{'{TOK_CONTENT, 8'h61, 1'b1}, NoTok, NoTok}},
      '{CommaByte, 1'b0, 1'b1, 2'd1, '{FieldLast, NoTok, NoTok}},
      '{QuoteByte, 1'b0, 1'b1, 2'd0, '{NoTok, NoTok, NoTok}},
      '{CommaByte, 1'b0, 1'b0, 2'd0, '{NoTok, NoTok, NoTok}},
      '{CrByte,    1'b0, 1'b0, 2'd0, '{NoTok, NoTok, NoTok}},
      '{QuoteByte, 1'b0, 1'b0, 2'd0, '{NoTok, NoTok, NoTok}},
      '{QuoteByte, 1'b0, 1'b0, 2'd0, '{NoTok, NoTok, NoTok}},
      '{QuoteByte, 1'b0, 1'b0, 2'd0, '{NoTok, NoTok, NoTok}},
      '{8'h78,     1'b0, 1'b0, 2'd0, '{NoTok, NoTok, NoTok}},
      '{CrByte,    1'b0, 1'b1, 2'd1, '{RecLast, NoTok, NoTok}},
      '{LfByte,    1'b0, 1'b1, 2'd0, '{NoTok, NoTok, NoTok}},
      '{LfByte,    1'b0, 1'b1, 2'd1, '{RecLast, NoTok, NoTok}},
      '{CrByte,    1'b0, 1'b0, 2'd0, '{NoTok, NoTok, NoTok}},
      '{8'h62,     1'b0, 1'b0, 2'd0, '{NoTok, NoTok, NoTok}},
      '{QuoteByte, 1'b0, 1'b0, 2'd0, '{NoTok, NoTok, NoTok}},
      '{CommaByte, 1'b0, 1'b0, 2'd0, '{NoTok, NoTok, NoTok}},
      '{8'h00,     1'b0, 1'b0, 2'd0, '{NoTok, NoTok, NoTok}},
      '{8'hff,     1'b1, 1'b1, 2'd2, '{'{TOK_CONTENT, 8'hff, 1'b0}, RecLast, NoTok}},
      '{CommaByte, 1'b1, 1'b1, 2'd2, '{FieldMid, RecLast, NoTok}},
      '{QuoteByte, 1'b1, 1'b1, 2'd1, '{RecLast, NoTok, NoTok}},
      '{LfByte,    1'b1, 1'b1, 2'd1, '{RecLast, NoTok, NoTok}},
      '{QuoteByte, 1'b0, 1'b0, 2'd0, '{NoTok, NoTok, NoTok}},
      '{8'h6b,     1'b0, 1'b0, 2'd0, '{NoTok, NoTok, NoTok}},
      '{QuoteByte, 1'b0, 1'b0, 2'd0, '{NoTok, NoTok, NoTok}},
      '{8'h6d,     1'b1, 1'b1, 2'd3,
        '{FieldMid, '{TOK_CONTENT, 8'h6d, 1'b0}, RecLast}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_byte = '0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_token_kind;
   logic [7:0]  rsp_content_byte;
   logic        rsp_run_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   scan_state_type   scan_model = ST_FIELD_START;
   logic             record_model = 1'b0;
   logic [7:0]       delim_model = CommaByte;
   token_expect_type step_tokens [$];
   token_expect_type pending_tokens [$];
   text_item_type    text_q [$];
   logic             idle_on = 1'b0;
   int               error_count = 0;
   int               quiet_cycles = 0;

   csv_record_tokenizer u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void add_token(token_kind_type kind, logic [7:0] value);
      step_tokens.push_back('{kind, value, 1'b0});
   endfunction

   function automatic logic take_separator(logic [7:0] c);
      if (c == delim_model) begin
         add_token(TOK_FIELD, 8'h00);
         scan_model = ST_FIELD_START;
         record_model = 1'b1;
         return 1'b1;
      end
      if (c == CrByte) begin
         add_token(TOK_RECORD, 8'h00);
         scan_model = ST_AFTER_CR;
         record_model = 1'b0;
         return 1'b1;
      end
      if (c == LfByte) begin
         add_token(TOK_RECORD, 8'h00);
         scan_model = ST_FIELD_START;
         record_model = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void tokenize_byte(logic [7:0] c, logic eot);
      logic swallowed;
      swallowed = 1'b0;
      step_tokens.delete();
      if (scan_model == ST_AFTER_CR) begin
         scan_model = ST_FIELD_START;
         swallowed = (c == LfByte);
      end
      if (!swallowed) begin
         case (scan_model)
            ST_UNQUOTED: begin
               if (!take_separator(c)) add_token(TOK_CONTENT, c);
            end
            ST_QUOTED: begin
               if (c == QuoteByte) scan_model = ST_QUOTE_SEEN;
               else add_token(TOK_CONTENT, c);
            end
            ST_QUOTE_SEEN: begin
               if (c == QuoteByte) begin
                  add_token(TOK_CONTENT, QuoteByte);
                  scan_model = ST_QUOTED;
               end else if (!take_separator(c)) begin
                  add_token(TOK_FIELD, 8'h00);
                  add_token(TOK_CONTENT, c);
                  scan_model = ST_UNQUOTED;
               end
            end
            default: begin
               if (c == QuoteByte) begin
                  scan_model = ST_QUOTED;
                  record_model = 1'b1;
               end else if (!take_separator(c)) begin
                  add_token(TOK_CONTENT, c);
                  scan_model = ST_UNQUOTED;
                  record_model = 1'b1;
               end
            end
         endcase
      end
      if (eot) begin
         if (record_model) add_token(TOK_RECORD, 8'h00);
         record_model = 1'b0;
         scan_model = ST_FIELD_START;
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
   endfunction

   function automatic void push_text(logic [7:0] c);
      text_q.push_back('{c, 1'b0});
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == delim_model || c == QuoteByte || c == CrByte || c == LfByte);
      return c;
   endfunction

   function automatic void build_text(int budget);
      logic [7:0] c;
      text_q.delete();
      while (text_q.size() < budget) begin
         if ($urandom_range(0, 7) == 0) begin
            push_text(8'($urandom_range(0, 255)));
         end else begin
            if ($urandom_range(0, 2) == 0) begin
               push_text(QuoteByte);
               repeat ($urandom_range(0, 4)) begin
                  case ($urandom_range(0, 4))
                     0: push_text(delim_model);
                     1: push_text(CrByte);
                     2: push_text(LfByte);
                     3: begin
                        push_text(QuoteByte);
                        push_text(QuoteByte);
                     end
                     default: begin
                        do c = 8'($urandom_range(0, 255));
                        while (c == QuoteByte);
                        push_text(c);
                     end
                  endcase
               end
               push_text(QuoteByte);
            end else begin
               repeat ($urandom_range(0, 4)) push_text(plain_byte());
            end
            case ($urandom_range(0, 5))
               0: push_text(CrByte);
               1: push_text(LfByte);
               2: begin
                  push_text(CrByte);
                  push_text(LfByte);
               end
               default: push_text(delim_model);
            endcase
         end
         if ($urandom_range(0, 9) == 0) text_q[text_q.size()-1].eot = 1'b1;
      end
   endfunction

   task automatic send_byte(input logic [7:0] c, input logic eot, input logic typed,
                            input int count, input token_triple_type toks);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= c;
      req_end_of_text <= eot;
      do @(posedge clock);
      while (req_stall);
      tokenize_byte(c, eot);
      if (typed) begin
         for (int i = 0; i < count; i++) pending_tokens.push_back(toks[i]);
      end else begin
         foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_read(input logic [2:0] addr, input logic [31:0] want);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      if (prdata !== want) begin
         $error("delimiter: expected %0h, got %0h", want, prdata);
         error_count++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [7:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      delim_model = value;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      csr_read(addr, 32'(value));
   endtask

   always begin
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      rsp_stall <= 1'b0;
   end

   always @(posedge clock) begin
      token_expect_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tokens.size() == 0) begin
            $error("token_kind: expected none, got %0d", rsp_token_kind);
            error_count++;
         end else begin
            want = pending_tokens.pop_front();
            if (rsp_token_kind !== want.kind) begin
               $error("token_kind: expected %0d, got %0d", want.kind, rsp_token_kind);
               error_count++;
            end
            if (rsp_content_byte !== want.content) begin
               $error("content_byte: expected %0h, got %0h", want.content, rsp_content_byte);
               error_count++;
            end
            if (rsp_run_last !== want.last) begin
               $error("run_last: expected %0d, got %0d", want.last, rsp_run_last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0] settings [8];
      settings = '{8'h00, 8'hff, QuoteByte, CrByte, LfByte, 8'h09, 8'h00, CommaByte};
      settings[6] = 8'($urandom_range(0, 255));
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_read(DelimiterAddr, 32'(CommaByte));
      idle_on = 1'b1;
      foreach (DirectedRows[i]) begin
         send_byte(DirectedRows[i].text, DirectedRows[i].eot, DirectedRows[i].typed,
                   DirectedRows[i].count, DirectedRows[i].toks);
      end
      drain();
      foreach (settings[p]) begin
         idle_on = (p % 3 != 2) && (p < 7);
         csr_write(DelimiterAddr, settings[p]);
         build_text(9);
         foreach (text_q[i]) send_byte(text_q[i].text, text_q[i].eot, 1'b0, 0, '0);
         drain();
      end
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* files.f */
src/csvt_pkg.sv
src/csvt_scan.sv
src/csvt_obuf.sv
src/csv_record_tokenizer.sv
src/csvt_checker.sv
verif/csv_record_tokenizer_tb.sv
